// ----- hw/rtl/rect_band_splitter_rotate_top_assert.svh -----
// Assertion macros for the band splitter.
`ifndef RECT_BAND_SPLITTER_ROTATE_TOP_ASSERT_SVH
`define RECT_BAND_SPLITTER_ROTATE_TOP_ASSERT_SVH

// Same-cycle implication.
`define RBSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define RBSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/rbsr_pkg.sv -----
`timescale 1ns / 1ps
package rbsr_pkg;

  localparam int IN_W        = 10;
  localparam int COORD_W     = 11;
  localparam int SUM_W       = 12;
  localparam int DVD_W       = 19;
  localparam int REM_W       = 12;
  localparam int DCNT_W      = 5;
  localparam int PROD_W      = 22;
  localparam int WIN_W       = 9;
  localparam int SRC_W       = 17;
  localparam int BCNT_W      = 4;
  localparam int BUF_W       = 3;
  localparam int MAX_RESULTS = 9;

  typedef struct packed {
    logic               empty;
    logic [COORD_W-1:0] first;
    logic [COORD_W-1:0] last;
    logic [COORD_W-1:0] from;
    logic [COORD_W-1:0] to;
  } rect_t;

endpackage

// ----- hw/rtl/rect_band_splitter_rotate_top.sv -----
// A taken request passes the combinational clamp, then a bit-serial restoring
// divide, then the band steps.
// Each band takes a row step, an offset multiply and an emit, and the emit
// waits while the output stalls; a request yields at most MAX_RESULTS bands.
// Reset: rst_ni asynchronous, active low; clears control state and the
// rotation register. Only one request is worked on at a time.
`timescale 1ns / 1ps
`include "rect_band_splitter_rotate_top_assert.svh"
module rect_band_splitter_rotate_top #(
  parameter int CANVAS_COLS  = 360,
  parameter int CANVAS_ROWS  = 360,
  parameter int BAND_LINES   = 40,
  parameter int BAND_BUFFERS = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [rbsr_pkg::IN_W-1:0]   rect_top_i,
  input  logic        [rbsr_pkg::IN_W-1:0]   rect_height_i,
  input  logic signed [rbsr_pkg::IN_W-1:0]   rect_left_i,
  input  logic        [rbsr_pkg::IN_W-1:0]   rect_width_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rbsr_pkg::WIN_W-1:0]         win_x_start_o,
  output logic [rbsr_pkg::WIN_W-1:0]         win_y_start_o,
  output logic [rbsr_pkg::WIN_W-1:0]         win_x_end_o,
  output logic [rbsr_pkg::WIN_W-1:0]         win_y_end_o,
  output logic [rbsr_pkg::WIN_W-1:0]         band_row_count_o,
  output logic [rbsr_pkg::SRC_W-1:0]         src_first_offset_o,
  output logic                               read_backwards_o,
  output logic                               buffer_index_o,
  output logic                               is_last_band_o
);

  localparam int CW = rbsr_pkg::COORD_W;
  localparam int DW = rbsr_pkg::DVD_W;
  localparam int PW = rbsr_pkg::PROD_W;
  localparam int WW = rbsr_pkg::WIN_W;
  localparam int SW = rbsr_pkg::SRC_W;
  localparam int BW = rbsr_pkg::BCNT_W;
  localparam int FW = rbsr_pkg::BUF_W;

  localparam logic [DW-1:0] DIVIDEND = DW'(CANVAS_COLS * BAND_LINES);
  localparam logic [CW-1:0] COLS_C   = CW'(CANVAS_COLS);
  localparam logic [CW-1:0] ROWS_C   = CW'(CANVAS_ROWS);
  localparam logic [PW-1:0] COLS_P   = PW'(CANVAS_COLS);
  localparam logic [FW-1:0] BUF_TOP  = FW'(BAND_BUFFERS - 1);
  localparam logic [BW-1:0] CNT_TOP  = BW'(rbsr_pkg::MAX_RESULTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_BAND = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]    state_q, state_d;
  logic          rot_q, rot_d;
  logic          ovld_q, ovld_d;
  logic          in_acc, load, div_start, div_done;
  logic [DW-1:0] quot;
  rbsr_pkg::rect_t rect;

  logic [CW-1:0] cursor_q, cursor_d, limit_q, limit_d, from_q, from_d, to_q, to_d;
  logic [CW-1:0] row_q, row_d, rows_q, rows_d, srow_q, srow_d, remain;
  logic [DW-1:0] rpb_q, rpb_d;
  logic [PW-1:0] prod_q, prod_d, src_sum;
  logic [BW-1:0] bcnt_q, bcnt_d;
  logic [FW-1:0] buf_q, buf_d;
  logic          last_q, last_d;
  logic [CW-1:0] span, x0, y0, x_end, y_end, col_sel;

  logic [WW-1:0] xs_q, xs_d, ys_q, ys_d, xe_q, xe_d, ye_q, ye_d, rc_q, rc_d;
  logic [SW-1:0] src_q, src_d;
  logic          rb_q, rb_d, bi_q, bi_d, lb_q, lb_d;

  rbsr_clamp #(
    .CANVAS_COLS(CANVAS_COLS),
    .CANVAS_ROWS(CANVAS_ROWS)
  ) u_clamp (
    .rect_top_i   (rect_top_i),
    .rect_height_i(rect_height_i),
    .rect_left_i  (rect_left_i),
    .rect_width_i (rect_width_i),
    .rect_o       (rect)
  );

  rbsr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(DIVIDEND),
    .divisor_i (span),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign div_start  = in_acc && !rect.empty;
  assign load       = (state_q == S_EMIT) && (!ovld_q || !out_stall_i);
  assign span       = to_q - from_q;
  assign remain     = limit_q - cursor_q;

  always_comb begin
    state_d  = state_q;
    rot_d    = cfg_we_i ? cfg_data_i : rot_q;
    ovld_d   = load || (ovld_q && out_stall_i);
    cursor_d = cursor_q;
    limit_d  = limit_q;
    from_d   = from_q;
    to_d     = to_q;
    row_d    = row_q;
    rows_d   = rows_q;
    srow_d   = srow_q;
    rpb_d    = rpb_q;
    prod_d   = prod_q;
    bcnt_d   = bcnt_q;
    buf_d    = buf_q;
    last_d   = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (div_start) begin
          cursor_d = rect.first;
          limit_d  = rect.last;
          from_d   = rect.from;
          to_d     = rect.to;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          rpb_d   = (quot == '0) ? DW'(1) : quot;
          bcnt_d  = '0;
          buf_d   = '0;
          state_d = S_BAND;
        end
      end
      S_BAND: begin
        rows_d   = (rpb_q <= DW'(remain)) ? rpb_q[CW-1:0] : remain;
        row_d    = cursor_q;
        cursor_d = cursor_q + rows_d;
        srow_d   = rot_q ? (cursor_d - CW'(1)) : cursor_q;
        last_d   = (cursor_d >= limit_q) || (bcnt_q >= CNT_TOP);
        state_d  = S_MUL;
      end
      S_MUL: begin
        prod_d  = PW'(srow_q) * COLS_P;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (load) begin
          bcnt_d  = bcnt_q + BW'(1);
          buf_d   = (buf_q >= BUF_TOP) ? '0 : buf_q + FW'(1);
          state_d = last_q ? S_IDLE : S_BAND;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    x0      = rot_q ? (COLS_C - to_q) : from_q;
    y0      = rot_q ? (ROWS_C - row_q - rows_q) : row_q;
    x_end   = x0 + span;
    y_end   = y0 + rows_q;
    col_sel = rot_q ? (to_q - CW'(1)) : from_q;
    src_sum = prod_q + PW'(col_sel);
    xs_d = load ? x0[WW-1:0] : xs_q;
    ys_d = load ? y0[WW-1:0] : ys_q;
    xe_d = load ? x_end[WW-1:0] : xe_q;
    ye_d = load ? y_end[WW-1:0] : ye_q;
    rc_d = load ? rows_q[WW-1:0] : rc_q;
    src_d = load ? src_sum[SW-1:0] : src_q;
    rb_d = load ? rot_q : rb_q;
    bi_d = load ? buf_q[0] : bi_q;
    lb_d = load ? last_q : lb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rot_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rot_q   <= rot_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q <= cursor_d;
    limit_q  <= limit_d;
    from_q   <= from_d;
    to_q     <= to_d;
    row_q    <= row_d;
    rows_q   <= rows_d;
    srow_q   <= srow_d;
    rpb_q    <= rpb_d;
    prod_q   <= prod_d;
    bcnt_q   <= bcnt_d;
    buf_q    <= buf_d;
    last_q   <= last_d;
    xs_q     <= xs_d;
    ys_q     <= ys_d;
    xe_q     <= xe_d;
    ye_q     <= ye_d;
    rc_q     <= rc_d;
    src_q    <= src_d;
    rb_q     <= rb_d;
    bi_q     <= bi_d;
    lb_q     <= lb_d;
  end

  assign out_valid_o        = ovld_q;
  assign win_x_start_o      = xs_q;
  assign win_y_start_o      = ys_q;
  assign win_x_end_o        = xe_q;
  assign win_y_end_o        = ye_q;
  assign band_row_count_o   = rc_q;
  assign src_first_offset_o = src_q;
  assign read_backwards_o   = rb_q;
  assign buffer_index_o     = bi_q;
  assign is_last_band_o     = lb_q;

  `RBSR_ASSERT_IMP(a_div_done_in_div, div_done, state_q == S_DIV)
  `RBSR_ASSERT_IMP(a_band_rows_nonzero, state_q == S_MUL, rows_q != '0)
  `RBSR_ASSERT_IMP(a_band_limit, state_q == S_EMIT, bcnt_q <= CNT_TOP)
  `RBSR_ASSERT_NXT(a_last_returns_idle, load && last_q, state_q == S_IDLE)

endmodule

// ----- hw/rtl/rbsr_clamp.sv -----
`timescale 1ns / 1ps
module rbsr_clamp #(
  parameter int CANVAS_COLS = 360,
  parameter int CANVAS_ROWS = 360
) (
  input  logic signed [rbsr_pkg::IN_W-1:0] rect_top_i,
  input  logic        [rbsr_pkg::IN_W-1:0] rect_height_i,
  input  logic signed [rbsr_pkg::IN_W-1:0] rect_left_i,
  input  logic        [rbsr_pkg::IN_W-1:0] rect_width_i,
  output rbsr_pkg::rect_t                  rect_o
);

  localparam int SW = rbsr_pkg::SUM_W;
  localparam int CW = rbsr_pkg::COORD_W;
  localparam int XW = SW - rbsr_pkg::IN_W;
  localparam logic signed [SW-1:0] ROWS_S = SW'(CANVAS_ROWS);
  localparam logic signed [SW-1:0] COLS_S = SW'(CANVAS_COLS);
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);

  logic signed [SW-1:0] top_s, left_s, hgt_s, wid_s;
  logic signed [SW-1:0] last_raw, to_raw;
  logic signed [SW-1:0] first_e, last_e, from_e, to_e;
  logic signed [SW-1:0] first_c, last_c, from_c, to_c;

  always_comb begin
    top_s    = {{XW{rect_top_i[rbsr_pkg::IN_W-1]}}, rect_top_i};
    left_s   = {{XW{rect_left_i[rbsr_pkg::IN_W-1]}}, rect_left_i};
    hgt_s    = {{XW{1'b0}}, rect_height_i};
    wid_s    = {{XW{1'b0}}, rect_width_i};
    last_raw = top_s + hgt_s + ONE_S;
    to_raw   = left_s + wid_s + ONE_S;
    // round toward minus infinity to even
    first_e  = {top_s[SW-1:1], 1'b0};
    last_e   = {last_raw[SW-1:1], 1'b0};
    from_e   = {left_s[SW-1:1], 1'b0};
    to_e     = {to_raw[SW-1:1], 1'b0};
    first_c  = first_e[SW-1] ? '0 : first_e;
    from_c   = from_e[SW-1] ? '0 : from_e;
    last_c   = (last_e > ROWS_S) ? ROWS_S : last_e;
    to_c     = (to_e > COLS_S) ? COLS_S : to_e;
    rect_o.empty = (first_c >= last_c) || (from_c >= to_c);
    rect_o.first = first_c[CW-1:0];
    rect_o.last  = last_c[CW-1:0];
    rect_o.from  = from_c[CW-1:0];
    rect_o.to    = to_c[CW-1:0];
  end

endmodule

// ----- hw/rtl/rbsr_div.sv -----
`timescale 1ns / 1ps
module rbsr_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rbsr_pkg::DVD_W-1:0]       dividend_i,
  input  logic [rbsr_pkg::COORD_W-1:0]     divisor_i,
  output logic                             done_o,
  output logic [rbsr_pkg::DVD_W-1:0]       quot_o
);

  localparam int DW = rbsr_pkg::DVD_W;
  localparam int RW = rbsr_pkg::REM_W;
  localparam int NW = rbsr_pkg::DCNT_W;

  logic          busy_q, busy_d, done_q, done_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] qd_q, qd_d;
  logic [RW-1:0] rem_q, rem_d, trial, dvs;

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    qd_d   = qd_q;
    rem_d  = rem_q;
    dvs    = {1'b0, divisor_i};
    trial  = {rem_q[RW-2:0], qd_q[DW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = NW'(DW);
      qd_d   = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= dvs) begin
        rem_d = trial - dvs;
        qd_d  = {qd_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        qd_d  = {qd_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qd_q  <= qd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = qd_q;

endmodule

// ----- tb/rect_band_splitter_rotate_checker.sv -----
`timescale 1ns / 1ps
module rect_band_splitter_rotate_checker #(
  parameter int CANVAS_COLS  = 360,
  parameter int CANVAS_ROWS  = 360,
  parameter int BAND_LINES   = 40,
  parameter int BAND_BUFFERS = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic signed [rbsr_pkg::IN_W-1:0] rect_top_i,
  input  logic        [rbsr_pkg::IN_W-1:0] rect_height_i,
  input  logic signed [rbsr_pkg::IN_W-1:0] rect_left_i,
  input  logic        [rbsr_pkg::IN_W-1:0] rect_width_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [rbsr_pkg::WIN_W-1:0]       win_x_start_i,
  input  logic [rbsr_pkg::WIN_W-1:0]       win_y_start_i,
  input  logic [rbsr_pkg::WIN_W-1:0]       win_x_end_i,
  input  logic [rbsr_pkg::WIN_W-1:0]       win_y_end_i,
  input  logic [rbsr_pkg::WIN_W-1:0]       band_row_count_i,
  input  logic [rbsr_pkg::SRC_W-1:0]       src_first_offset_i,
  input  logic                             read_backwards_i,
  input  logic                             buffer_index_i,
  input  logic                             is_last_band_i,
  output int                               fail_count_o,
  output int                               words_pending_o
);
  localparam int IN_W        = rbsr_pkg::IN_W;
  localparam int WIN_W       = rbsr_pkg::WIN_W;
  localparam int SRC_W       = rbsr_pkg::SRC_W;
  localparam int BCNT_W      = rbsr_pkg::BCNT_W;
  localparam int MAX_RESULTS = rbsr_pkg::MAX_RESULTS;

  typedef struct packed {
    logic [WIN_W-1:0] x_start;
    logic [WIN_W-1:0] y_start;
    logic [WIN_W-1:0] x_end;
    logic [WIN_W-1:0] y_end;
    logic [WIN_W-1:0] rows;
    logic [SRC_W-1:0] src;
    logic             backwards;
    logic             buf_idx;
    logic             last_band;
  } band_word_t;

  band_word_t band_q[$];
  band_word_t got_word;
  band_word_t want_word;
  int         mismatches = 0;

  // shadow of the block's state
  logic              half_turn;
  logic [WIN_W-1:0]  band_cursor;
  logic [WIN_W-1:0]  row_end;
  logic [WIN_W-1:0]  col_lo;
  logic [WIN_W-1:0]  col_hi;
  logic [12:0]       band_height;
  logic [BCNT_W-1:0] bands_done;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      flag_mismatch($sformatf("word field %s: got %0d, want %0d", name, got, want));
    end
  endtask

  task automatic split_rect(input logic signed [IN_W-1:0] top,
                            input logic [IN_W-1:0] height,
                            input logic signed [IN_W-1:0] left,
                            input logic [IN_W-1:0] width);
    int first, last, from, to, span, row, rows, x0, y0, src, n;
    band_word_t w;
    // round start down and end up to even
    first = int'(top) & ~1;
    last  = (int'(top) + int'(height) + 1) & ~1;
    from  = int'(left) & ~1;
    to    = (int'(left) + int'(width) + 1) & ~1;
    if (first < 0) first = 0;
    if (last > CANVAS_ROWS) last = CANVAS_ROWS;
    if (from < 0) from = 0;
    if (to > CANVAS_COLS) to = CANVAS_COLS;
    if (first >= last || from >= to) return;
    span        = to - from;
    row_end     = WIN_W'(last);
    col_lo      = WIN_W'(from);
    col_hi      = WIN_W'(to);
    band_height = 13'((CANVAS_COLS * BAND_LINES) / span);
    if (band_height == 0) band_height = 13'd1;
    band_cursor = WIN_W'(first);
    bands_done  = '0;
    n = 0;
    while (int'(band_cursor) < int'(row_end) && n < MAX_RESULTS) begin
      row  = int'(band_cursor);
      rows = (row + int'(band_height) <= int'(row_end)) ? int'(band_height)
                                                         : int'(row_end) - row;
      if (half_turn) begin
        y0  = CANVAS_ROWS - row - rows;
        x0  = CANVAS_COLS - int'(col_hi);
        src = (row + rows - 1) * CANVAS_COLS + int'(col_hi) - 1;
      end else begin
        y0  = row;
        x0  = int'(col_lo);
        src = row * CANVAS_COLS + int'(col_lo);
      end
      band_cursor = WIN_W'(row + rows);
      w.x_start   = WIN_W'(x0);
      w.y_start   = WIN_W'(y0);
      w.x_end     = WIN_W'(x0 + span);
      w.y_end     = WIN_W'(y0 + rows);
      w.rows      = WIN_W'(rows);
      w.src       = SRC_W'(src);
      w.backwards = half_turn;
      w.buf_idx   = 1'(int'(bands_done) % BAND_BUFFERS);
      w.last_band = (int'(band_cursor) >= int'(row_end)) || (n + 1 >= MAX_RESULTS);
      bands_done  = bands_done + BCNT_W'(1);
      band_q.push_back(w);
      n++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_turn   = 1'b0;
      band_cursor = '0;
      row_end     = '0;
      col_lo      = '0;
      col_hi      = '0;
      band_height = '0;
      bands_done  = '0;
      band_q.delete();
      fail_count_o    <= mismatches;
      words_pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_word.x_start   = win_x_start_i;
        got_word.y_start   = win_y_start_i;
        got_word.x_end     = win_x_end_i;
        got_word.y_end     = win_y_end_i;
        got_word.rows      = band_row_count_i;
        got_word.src       = src_first_offset_i;
        got_word.backwards = read_backwards_i;
        got_word.buf_idx   = buffer_index_i;
        got_word.last_band = is_last_band_i;
        if (band_q.size() == 0) begin
          flag_mismatch("band word with none expected");
        end else begin
          want_word = band_q.pop_front();
          check_field("win_x_start", int'(got_word.x_start), int'(want_word.x_start));
          check_field("win_y_start", int'(got_word.y_start), int'(want_word.y_start));
          check_field("win_x_end", int'(got_word.x_end), int'(want_word.x_end));
          check_field("win_y_end", int'(got_word.y_end), int'(want_word.y_end));
          check_field("band_row_count", int'(got_word.rows), int'(want_word.rows));
          check_field("src_first_offset", int'(got_word.src), int'(want_word.src));
          check_field("read_backwards", int'(got_word.backwards),
                      int'(want_word.backwards));
          check_field("buffer_index", int'(got_word.buf_idx), int'(want_word.buf_idx));
          check_field("is_last_band", int'(got_word.last_band),
                      int'(want_word.last_band));
        end
      end
      if (cfg_we_i) half_turn = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        split_rect(rect_top_i, rect_height_i, rect_left_i, rect_width_i);
      end
      fail_count_o    <= mismatches;
      words_pending_o <= band_q.size();
    end
  end

endmodule

// ----- tb/rect_band_splitter_rotate_top_tb.sv -----
`timescale 1ns / 1ps
module rect_band_splitter_rotate_top_tb;
  localparam int IN_W  = rbsr_pkg::IN_W;
  localparam int WIN_W = rbsr_pkg::WIN_W;
  localparam int SRC_W = rbsr_pkg::SRC_W;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RAND_PER_PHASE = 48;
  localparam int IDLE_PCT       = 17;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_data_i = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [IN_W-1:0] rect_top_i = '0;
  logic        [IN_W-1:0] rect_height_i = '0;
  logic signed [IN_W-1:0] rect_left_i = '0;
  logic        [IN_W-1:0] rect_width_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [WIN_W-1:0]       win_x_start_o;
  logic [WIN_W-1:0]       win_y_start_o;
  logic [WIN_W-1:0]       win_x_end_o;
  logic [WIN_W-1:0]       win_y_end_o;
  logic [WIN_W-1:0]       band_row_count_o;
  logic [SRC_W-1:0]       src_first_offset_o;
  logic                   read_backwards_o;
  logic                   buffer_index_o;
  logic                   is_last_band_o;

  int   fail_count;
  int   words_pending;
  int   cycle_count = 0;
  logic calm = 1'b0;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  rect_band_splitter_rotate_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rect_top_i         (rect_top_i),
    .rect_height_i      (rect_height_i),
    .rect_left_i        (rect_left_i),
    .rect_width_i       (rect_width_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .win_x_start_o      (win_x_start_o),
    .win_y_start_o      (win_y_start_o),
    .win_x_end_o        (win_x_end_o),
    .win_y_end_o        (win_y_end_o),
    .band_row_count_o   (band_row_count_o),
    .src_first_offset_o (src_first_offset_o),
    .read_backwards_o   (read_backwards_o),
    .buffer_index_o     (buffer_index_o),
    .is_last_band_o     (is_last_band_o)
  );

  rect_band_splitter_rotate_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .rect_top_i         (rect_top_i),
    .rect_height_i      (rect_height_i),
    .rect_left_i        (rect_left_i),
    .rect_width_i       (rect_width_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .win_x_start_i      (win_x_start_o),
    .win_y_start_i      (win_y_start_o),
    .win_x_end_i        (win_x_end_o),
    .win_y_end_i        (win_y_end_o),
    .band_row_count_i   (band_row_count_o),
    .src_first_offset_i (src_first_offset_o),
    .read_backwards_i   (read_backwards_o),
    .buffer_index_i     (buffer_index_o),
    .is_last_band_i     (is_last_band_o),
    .fail_count_o       (fail_count),
    .words_pending_o    (words_pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_rect(input int top, input int height,
                           input int left, input int width);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rect_top_i    <= IN_W'(top);
    rect_height_i <= IN_W'(height);
    rect_left_i   <= IN_W'(left);
    rect_width_i  <= IN_W'(width);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // waits until no expected band word is pending, then drains further
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_rotation(input logic half_turn);
    wait_for_drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= half_turn;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic int pick_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 40);
    if (sel < 8) return $urandom_range(41, 400);
    return $urandom_range(0, 1023);
  endfunction

  initial begin
    int t, h, l, w, idx;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_rotation(1'b0);
    send_rect(0, 360, 0, 360);
    send_rect(0, 0, 0, 0);
    send_rect(-512, 1023, -512, 1023);
    send_rect(511, 1023, 511, 1023);
    send_rect(1, 1, 1, 1);
    send_rect(359, 1, 359, 1);
    send_rect(-3, 4, -3, 4);
    send_rect(-512, 0, 0, 100);
    send_rect(100, 50, -100, 50);
    send_rect(0, 360, 0, 2);
    send_rect(10, 200, 100, 181);
    send_rect(300, 100, 0, 360);
    send_rect(-512, 1023, 0, 1023);

    set_rotation(1'b1);
    send_rect(0, 360, 0, 360);
    send_rect(1, 1, 1, 1);
    send_rect(359, 1, 359, 1);
    send_rect(33, 77, 123, 45);
    send_rect(0, 1023, -512, 600);
    send_rect(511, 0, -512, 0);
    send_rect(200, 1023, 300, 1023);

    idx = 0;
    for (int p = 0; p < 4; p++) begin
      set_rotation(p[0]);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        calm <= (idx >= 70 && idx < 125);
        if ($urandom_range(0, 99) < 20) begin
          t = $urandom_range(0, 1023);
          h = $urandom_range(0, 1023);
          l = $urandom_range(0, 1023);
          w = $urandom_range(0, 1023);
        end else begin
          t = $urandom_range(0, 371) - 8;
          h = pick_size();
          l = $urandom_range(0, 371) - 8;
          w = pick_size();
        end
        send_rect(t, h, l, w);
        idx++;
      end
    end
    calm <= 1'b0;

    wait_for_drain();
    if (fail_count == 0 && words_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- rect_band_splitter_rotate_top.f -----
+incdir+hw/rtl
hw/rtl/rbsr_pkg.sv
hw/rtl/rbsr_clamp.sv
hw/rtl/rbsr_div.sv
hw/rtl/rect_band_splitter_rotate_top.sv
tb/rect_band_splitter_rotate_checker.sv
tb/rect_band_splitter_rotate_top_tb.sv
